// ===== rtl/spool_pkg.sv =====
// Shared types and constants for the slot pool with ordered in-use list.
`timescale 1ns / 1ps
`default_nettype none
package spool_pkg;

   localparam int POOL_SLOTS = 32;
   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int CNT_W      = SLOT_W + 1;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_LIST  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOT_USED = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_FREE_WALK,
      S_FREE_UNLINK,
      S_FREE_HEAD,
      S_FREE_PUSH,
      S_LIST,
      S_REPORT
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/slot_pool_with_ordered_active_list_unit.sv =====
// Slot pool allocator: free stack and ordered in-use list sharing one link memory.
//
// Usage: one request word on req_* (action, slot), results on rsp_* (status,
// slot_out, last). A word moves when valid is high and stall is low.
// Requests are handled one at a time; req_stall is low only while idle.
// Steps per request, paced by the link memory (one read per cycle):
//   allocate: free-head link read, then the update into the result register.
//   free: if the slot heads the in-use list, its own link read, then the update;
//     else a predecessor walk (one link/cycle), the unlink, then the push.
//   list: the first link read, then one result per cycle while rsp_stall allows.
//   errors (pool full, slot not in use, list empty): straight to the report.
// A finished result waits in the output register while the next request is
// accepted; rsp_stall only holds that register and delays the next result.
// Reset (synchronous): free list 0..31 in order, in-use list empty. Link
// entries read as their reset value until first written (valid bit per
// entry), so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module slot_pool_with_ordered_active_list_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_action,
   input  wire logic [spool_pkg::SLOT_W-1:0]  req_slot,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [spool_pkg::SLOT_W-1:0]       rsp_slot_out,
   output logic                               rsp_last
);

   localparam int SW = spool_pkg::SLOT_W;
   localparam int CW = spool_pkg::CNT_W;
   localparam int NS = spool_pkg::POOL_SLOTS;

   spool_pkg::state_type  state_ff, state_in;
   logic [SW-1:0]         free_head_ff, free_head_in;
   logic [CW-1:0]         free_count_ff, free_count_in;
   logic [SW-1:0]         used_head_ff, used_head_in;
   logic [SW-1:0]         used_tail_ff, used_tail_in;
   logic [CW-1:0]         used_count_ff, used_count_in;
   logic [NS-1:0]         flags_ff, flags_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [SW-1:0]         cur_ff, cur_in;
   logic [SW-1:0]         prev_ff, prev_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   spool_pkg::status_type res_status_ff, res_status_in;
   logic [SW-1:0]         res_slot_ff, res_slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [SW-1:0]         rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   // link memory
   logic [SW-1:0]         link_mem [NS];
   logic [NS-1:0]         link_vld_ff;
   logic                  rd_en;
   logic [SW-1:0]         rd_addr;
   logic [SW-1:0]         rd_link_ff;
   logic                  wr_en;
   logic [SW-1:0]         wr_addr;
   logic [SW-1:0]         wr_data;

   logic                  req_fire;
   logic                  out_free;
   logic                  list_last;

   assign req_stall = (state_ff != spool_pkg::S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign list_last = ((cnt_ff + CW'(1)) == used_count_ff);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spool_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (req_action)
                  spool_pkg::ACT_ALLOC: begin
                     state_in = (free_count_ff == '0) ? spool_pkg::S_REPORT
                                                       : spool_pkg::S_ALLOC;
                  end
                  spool_pkg::ACT_FREE: begin
                     priority if (!flags_ff[req_slot])
                        state_in = spool_pkg::S_REPORT;
                     else if (req_slot == used_head_ff)
                        state_in = spool_pkg::S_FREE_HEAD;
                     else
                        state_in = spool_pkg::S_FREE_WALK;
                  end
                  spool_pkg::ACT_LIST: begin
                     state_in = (used_count_ff == '0) ? spool_pkg::S_REPORT
                                                       : spool_pkg::S_LIST;
                  end
                  default: state_in = spool_pkg::S_IDLE;
               endcase
            end
         end
         spool_pkg::S_ALLOC:       state_in = spool_pkg::S_REPORT;
         spool_pkg::S_FREE_WALK: begin
            if (rd_link_ff == slot_ff) state_in = spool_pkg::S_FREE_UNLINK;
         end
         spool_pkg::S_FREE_UNLINK: state_in = spool_pkg::S_FREE_PUSH;
         spool_pkg::S_FREE_HEAD:   state_in = spool_pkg::S_REPORT;
         spool_pkg::S_FREE_PUSH:   state_in = spool_pkg::S_REPORT;
         spool_pkg::S_LIST: begin
            if (out_free && list_last) state_in = spool_pkg::S_IDLE;
         end
         spool_pkg::S_REPORT: begin
            if (out_free) state_in = spool_pkg::S_IDLE;
         end
         default: state_in = spool_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      used_head_in  = used_head_ff;
      used_tail_in  = used_tail_ff;
      used_count_in = used_count_ff;
      flags_in      = flags_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = free_head_ff;

      unique case (state_ff)
         spool_pkg::S_IDLE: begin
            if (req_fire) begin
               slot_in = req_slot;
               unique case (req_action)
                  spool_pkg::ACT_ALLOC: begin
                     res_status_in = spool_pkg::ST_FULL;
                     res_slot_in   = '0;
                     rd_en         = 1'b1;
                     rd_addr       = free_head_ff;
                  end
                  spool_pkg::ACT_FREE: begin
                     res_status_in = spool_pkg::ST_NOT_USED;
                     res_slot_in   = req_slot;
                     cur_in        = used_head_ff;
                     rd_en         = 1'b1;
                     // head case reads the slot's own link, else start the walk
                     rd_addr       = used_head_ff;
                  end
                  spool_pkg::ACT_LIST: begin
                     res_status_in = spool_pkg::ST_EMPTY;
                     res_slot_in   = '0;
                     cur_in        = used_head_ff;
                     cnt_in        = '0;
                     rd_en         = 1'b1;
                     rd_addr       = used_head_ff;
                  end
                  default: begin
                     res_status_in = res_status_ff;
                  end
               endcase
            end
         end
         spool_pkg::S_ALLOC: begin
            free_head_in  = rd_link_ff;
            free_count_in = free_count_ff - CW'(1);
            if (used_count_ff == '0) begin
               used_head_in = free_head_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = used_tail_ff;
               wr_data = free_head_ff;
            end
            used_tail_in            = free_head_ff;
            used_count_in           = used_count_ff + CW'(1);
            flags_in[free_head_ff]  = 1'b1;
            res_status_in           = spool_pkg::ST_OK;
            res_slot_in             = free_head_ff;
         end
         spool_pkg::S_FREE_WALK: begin
            rd_en = 1'b1;
            if (rd_link_ff == slot_ff) begin
               prev_in = cur_ff;
               rd_addr = slot_ff;
            end else begin
               cur_in  = rd_link_ff;
               rd_addr = rd_link_ff;
            end
         end
         spool_pkg::S_FREE_UNLINK: begin
            wr_en   = 1'b1;
            wr_addr = prev_ff;
            wr_data = rd_link_ff;
            if (slot_ff == used_tail_ff) used_tail_in = prev_ff;
         end
         spool_pkg::S_FREE_HEAD, spool_pkg::S_FREE_PUSH: begin
            if (state_ff == spool_pkg::S_FREE_HEAD) used_head_in = rd_link_ff;
            wr_en             = 1'b1;
            wr_addr           = slot_ff;
            wr_data           = free_head_ff;
            free_head_in      = slot_ff;
            free_count_in     = free_count_ff + CW'(1);
            used_count_in     = used_count_ff - CW'(1);
            flags_in[slot_ff] = 1'b0;
            res_status_in     = spool_pkg::ST_OK;
            res_slot_in       = slot_ff;
         end
         spool_pkg::S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = spool_pkg::ST_OK;
               rsp_slot_in   = cur_ff;
               rsp_last_in   = list_last;
               cnt_in        = cnt_ff + CW'(1);
               cur_in        = rd_link_ff;
               rd_en         = 1'b1;
               rd_addr       = rd_link_ff;
            end
         end
         spool_pkg::S_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spool_pkg::S_IDLE;
         free_head_ff  <= '0;
         free_count_ff <= CW'(NS);
         used_head_ff  <= '0;
         used_tail_ff  <= '0;
         used_count_ff <= '0;
         flags_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         link_vld_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         used_head_ff  <= used_head_in;
         used_tail_ff  <= used_tail_in;
         used_count_ff <= used_count_in;
         flags_ff      <= flags_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_en) link_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // link memory: unwritten entries read as index plus one (mod pool size)
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_link_ff <= link_vld_ff[rd_addr] ? link_mem[rd_addr]
                                            : rd_addr + SW'(1);
      end
   end

`ifndef ASSERT_OFF
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff + used_count_ff) == CW'(NS))
      else $error("free and used counts do not add up to the pool size");

   a_flags_count: assert property (@(posedge clock) disable iff (reset)
      $countones(flags_ff) == used_count_ff)
      else $error("in-use flags disagree with used count");

   a_free_head_free: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff != '0) |-> !flags_ff[free_head_ff])
      else $error("free list head is marked in use");

   a_list_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spool_pkg::S_LIST) |-> flags_ff[cur_ff])
      else $error("list walk reached a slot that is not in use");
`endif

endmodule
`default_nettype wire
